// ===== hw/rtl/pair_distance_histogram_pbc_core_macros.svh =====
// Assertion macros for the pair distance histogram core.
// Used by the top level only; expects i_clk and i_rst_n in scope.
`ifndef PAIR_DISTANCE_HISTOGRAM_PBC_CORE_MACROS_SVH
`define PAIR_DISTANCE_HISTOGRAM_PBC_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PDH_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PDH_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/pdh_pkg.sv =====
// Shared types and constants for the pair distance histogram core.
// No dependencies; imported by every module of the block.
package pdh_pkg;

    localparam int DEF_MAX_PARTICLES = 256;
    localparam int DEF_NUM_BINS      = 64;
    localparam int DEF_COORD_BITS    = 16;

    // Bin edge (k+1)*bin_size and its square.
    localparam int EDGE_W = 23;
    localparam int THR_W  = 2 * EDGE_W;

    localparam int CFG_AW = 2;
    localparam logic [CFG_AW-1:0] CFG_BOX_LENGTH  = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_BIN_SIZE    = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_BINS_IN_USE = 2'd2;

    localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;

    // Token control that travels with a squared distance along the bin chain.
    typedef struct packed {
        logic valid;
        logic claimed;
    } t_cell_ctl;

endpackage

// ===== hw/rtl/pdh_bin_cell.sv =====
// One histogram bin of the chain: holds its count and squared upper edge.
// Depends on pdh_pkg.
module pdh_bin_cell #(
    parameter int D2_W = 36
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  pdh_pkg::t_cell_ctl     i_ctl,
    input  logic [D2_W-1:0]        i_d2,
    input  logic [pdh_pkg::THR_W-1:0] i_thr,
    input  logic                   i_thr_shift,
    input  logic                   i_is_last,
    input  logic                   i_rotate,
    input  logic [31:0]            i_hist,
    output pdh_pkg::t_cell_ctl     o_ctl,
    output logic [D2_W-1:0]        o_d2,
    output logic [pdh_pkg::THR_W-1:0] o_thr,
    output logic [31:0]            o_hist
);
    import pdh_pkg::*;

    localparam int CMP_W = (D2_W > THR_W) ? D2_W : THR_W;

    logic [THR_W-1:0] r_thr;
    logic [31:0]      r_hist;
    t_cell_ctl        r_ctl;
    logic [D2_W-1:0]  r_d2;
    logic             hit;

    // The first cell whose upper edge lies above the distance, or the last bin in use, takes the pair.
    assign hit = i_ctl.valid && !i_ctl.claimed &&
                 ((CMP_W'(i_d2) < CMP_W'(r_thr)) || i_is_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist <= '0;
            r_ctl  <= '0;
        end else begin
            if (i_rotate) begin
                r_hist <= i_hist;
            end else if (hit) begin
                r_hist <= (r_hist > SAT32 - 32'd2) ? SAT32 : r_hist + 32'd2;
            end
            r_ctl.valid   <= i_ctl.valid;
            r_ctl.claimed <= i_ctl.claimed || hit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d2 <= i_d2;
        if (i_thr_shift) begin
            r_thr <= i_thr;
        end
    end

    assign o_ctl  = r_ctl;
    assign o_d2   = r_d2;
    assign o_thr  = r_thr;
    assign o_hist = r_hist;
endmodule

// ===== hw/rtl/pdh_pair_pipe.sv =====
// Particle stores and the pair pipeline: minimum image, squares, range test.
// Depends on pdh_pkg.
module pdh_pair_pipe #(
    parameter int MAX_PARTICLES = pdh_pkg::DEF_MAX_PARTICLES,
    parameter int COORD_BITS    = pdh_pkg::DEF_COORD_BITS,
    parameter int AW            = $clog2(MAX_PARTICLES),
    parameter int D2_W          = 2 * COORD_BITS + 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_wr_en,
    input  logic [AW-1:0]         i_wr_addr,
    input  logic [COORD_BITS-1:0] i_wr_x,
    input  logic [COORD_BITS-1:0] i_wr_y,
    input  logic [COORD_BITS-1:0] i_wr_z,
    input  logic                  i_issue,
    input  logic [AW-1:0]         i_addr_a,
    input  logic [AW-1:0]         i_addr_b,
    input  logic [15:0]           i_box_length,
    input  logic [31:0]           i_box_sq,
    output pdh_pkg::t_cell_ctl    o_ctl,
    output logic [D2_W-1:0]       o_d2
);
    import pdh_pkg::*;

    localparam int CB = COORD_BITS;
    localparam int MW = CB + 16;
    localparam int FW = (CB + 1 > 17) ? CB + 1 : 17;
    localparam int RW = (D2_W + 2 > 32) ? D2_W + 2 : 32;

    logic [CB-1:0] mem_x [MAX_PARTICLES];
    logic [CB-1:0] mem_y [MAX_PARTICLES];
    logic [CB-1:0] mem_z [MAX_PARTICLES];

    logic          r_v1;
    logic [CB-1:0] r_xa, r_xb, r_ya, r_yb, r_za, r_zb;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem_x[i_wr_addr] <= i_wr_x;
            mem_y[i_wr_addr] <= i_wr_y;
            mem_z[i_wr_addr] <= i_wr_z;
        end
        r_xa <= mem_x[i_addr_a];
        r_xb <= mem_x[i_addr_b];
        r_ya <= mem_y[i_addr_a];
        r_yb <= mem_y[i_addr_b];
        r_za <= mem_z[i_addr_a];
        r_zb <= mem_z[i_addr_b];
    end

    // Absolute differences.
    logic signed [CB:0] dz_s;
    logic          r_v2;
    logic [CB-1:0] r_adx, r_ady;
    logic [CB:0]   r_adz2;

    assign dz_s = $signed({r_za[CB-1], r_za}) - $signed({r_zb[CB-1], r_zb});

    always_ff @(posedge i_clk) begin
        r_adx  <= (r_xa >= r_xb) ? r_xa - r_xb : r_xb - r_xa;
        r_ady  <= (r_ya >= r_yb) ? r_ya - r_yb : r_yb - r_ya;
        r_adz2 <= dz_s[CB] ? (CB+1)'(-dz_s) : (CB+1)'(dz_s);
    end

    // Restoring reduction modulo the box length, one shifted subtract per stage.
    logic [CB-1:0] r_mx [CB+1];
    logic [CB-1:0] r_my [CB+1];
    logic [CB:0]   r_mz [CB+1];
    logic          r_mv [CB+1];

    always_comb begin
        r_mx[0] = r_adx;
        r_my[0] = r_ady;
        r_mz[0] = r_adz2;
        r_mv[0] = r_v2;
    end

    for (genvar s = 0; s < CB; s++) begin : g_mod
        localparam int SH = CB - 1 - s;
        logic [MW-1:0] lsh;
        assign lsh = MW'(i_box_length) << SH;
        always_ff @(posedge i_clk) begin
            r_mx[s+1] <= (MW'(r_mx[s]) >= lsh) ? CB'(MW'(r_mx[s]) - lsh) : r_mx[s];
            r_my[s+1] <= (MW'(r_my[s]) >= lsh) ? CB'(MW'(r_my[s]) - lsh) : r_my[s];
            r_mz[s+1] <= r_mz[s];
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_mv[s+1] <= 1'b0;
            end else begin
                r_mv[s+1] <= r_mv[s];
            end
        end
    end

    // Fold the residue into the half box; the sign is lost in the square anyway.
    logic          r_v3;
    logic [15:0]   r_magx, r_magy;
    logic [CB:0]   r_magz;

    always_ff @(posedge i_clk) begin
        r_magx <= (FW'({r_mx[CB], 1'b0}) >= FW'(i_box_length)) ?
                  i_box_length - 16'(r_mx[CB]) : 16'(r_mx[CB]);
        r_magy <= (FW'({r_my[CB], 1'b0}) >= FW'(i_box_length)) ?
                  i_box_length - 16'(r_my[CB]) : 16'(r_my[CB]);
        r_magz <= r_mz[CB];
    end

    logic                r_v4;
    logic [31:0]         r_sqx, r_sqy;
    logic [2*CB+1:0]     r_sqz;

    always_ff @(posedge i_clk) begin
        r_sqx <= 32'(r_magx) * 32'(r_magx);
        r_sqy <= 32'(r_magy) * 32'(r_magy);
        r_sqz <= (2*CB+2)'(r_magz) * (2*CB+2)'(r_magz);
    end

    logic [D2_W-1:0] d2_sum;
    logic [D2_W-1:0] r_d2;
    t_cell_ctl       r_ctl;

    assign d2_sum = D2_W'(r_sqx) + D2_W'(r_sqy) + D2_W'(r_sqz);

    always_ff @(posedge i_clk) begin
        r_d2 <= d2_sum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_v3  <= 1'b0;
            r_v4  <= 1'b0;
            r_ctl <= '0;
        end else begin
            r_v1          <= i_issue;
            r_v2          <= r_v1;
            r_v3          <= r_mv[CB];
            r_v4          <= r_v3;
            r_ctl.valid   <= r_v4;
            // Out of range pairs enter the chain already claimed.
            r_ctl.claimed <= !(RW'({d2_sum, 2'b00}) < RW'(i_box_sq));
        end
    end

    assign o_ctl = r_ctl;
    assign o_d2  = r_d2;
endmodule

// ===== hw/rtl/pair_distance_histogram_pbc_core.sv =====
// Top level of the pair distance histogram core with periodic x and y.
// Depends on pdh_pkg, pdh_pair_pipe, pdh_bin_cell and the macros header.

// Particles of a frame are taken one transaction per cycle, while the block
// is loading, into three position memories of MAX_PARTICLES entries. The
// transaction that carries last_particle starts the frame work and the input
// stays blocked until the report is done: first the squared bin edges are
// computed with two registered multiplies and shifted into the bin chain,
// then the pair pass issues one unordered pair per cycle, N*(N-1)/2 pairs for
// N stored particles, then the pipeline and the chain drain, then the
// histogram rotates out through all NUM_BINS cells, one bin per cycle when
// the sink is ready. The pair rate of one per cycle is set by the two read
// ports of the position memories. Each pair passes a pipeline that
// reduces x and y modulo the box length with one shifted subtract per stage,
// squares the folded differences and tests 4*d2 < L*L. The squared distance
// then travels along a chain of NUM_BINS cells; the first cell whose squared
// upper edge lies above it adds 2 to its saturating count, and the last bin
// in use takes everything beyond. A frame with fewer than two particles or a
// zero box length counts no pairs but still reports. Configuration writes are
// taken at any time and must only happen while the block is idle.
module pair_distance_histogram_pbc_core #(
    parameter int MAX_PARTICLES = pdh_pkg::DEF_MAX_PARTICLES,
    parameter int NUM_BINS      = pdh_pkg::DEF_NUM_BINS,
    parameter int COORD_BITS    = pdh_pkg::DEF_COORD_BITS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [pdh_pkg::CFG_AW-1:0] i_cfg_addr,
    input  logic [15:0]               i_cfg_data,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [15:0]               i_pos_x,
    input  logic [15:0]               i_pos_y,
    input  logic signed [15:0]        i_pos_z,
    input  logic                      i_last_particle,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [5:0]                o_bin_index,
    output logic [31:0]               o_bin_total,
    output logic [31:0]               o_frames_sampled,
    output logic                      o_capacity_overflow,
    output logic                      o_last_bin
);
    import pdh_pkg::*;
    `include "pair_distance_histogram_pbc_core_macros.svh"

    localparam int AW        = $clog2(MAX_PARTICLES);
    localparam int CW        = $clog2(MAX_PARTICLES + 1);
    localparam int BW        = $clog2(NUM_BINS + 1);
    localparam int D2_W      = 2 * COORD_BITS + 4;
    localparam int DRAIN_CYC = COORD_BITS + NUM_BINS + 8;
    localparam int DW        = $clog2(DRAIN_CYC + 1);

    localparam logic [2:0] S_LOAD   = 3'd0;
    localparam logic [2:0] S_THR    = 3'd1;
    localparam logic [2:0] S_PAIR   = 3'd2;
    localparam logic [2:0] S_DRAIN  = 3'd3;
    localparam logic [2:0] S_REPORT = 3'd4;

    // Configuration registers.
    logic [15:0] r_box_length, r_bin_size;
    logic [6:0]  r_bins_in_use;
    logic [31:0] r_box_sq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box_length  <= 16'd65535;
            r_bin_size    <= 16'd1024;
            r_bins_in_use <= 7'd64;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_BOX_LENGTH:  r_box_length  <= i_cfg_data;
                CFG_BIN_SIZE:    r_bin_size    <= i_cfg_data;
                CFG_BINS_IN_USE: r_bins_in_use <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // The user changes box length only while idle; the block does not enforce it.
    always_ff @(posedge i_clk) begin
        r_box_sq <= 32'(r_box_length) * 32'(r_box_length);
    end

    logic [6:0]  nb_eff;
    logic [15:0] bs_eff;

    assign nb_eff = (r_bins_in_use == 7'd0) ? 7'd1 :
                    (r_bins_in_use > 7'(NUM_BINS)) ? 7'(NUM_BINS) : r_bins_in_use;
    assign bs_eff = (r_bin_size == 16'd0) ? 16'd1 : r_bin_size;

    // Control state.
    logic [2:0]    r_state, n_state;
    logic [CW-1:0] r_count;
    logic          r_dropped;
    logic [31:0]   r_frames;
    logic [AW-1:0] r_i, r_j;
    logic [BW-1:0] r_tk;
    logic          r_t1v, r_t2v;
    logic [EDGE_W-1:0] r_edge;
    logic [THR_W-1:0]  r_thr;
    logic [DW-1:0] r_drain;
    logic [BW-1:0] r_ridx;

    logic in_acc, store_ok, pair_skip, pair_end, emit, out_load, rot_step;

    assign o_in_ready = (r_state == S_LOAD);
    assign in_acc     = i_in_valid && o_in_ready;
    assign store_ok   = (r_count < CW'(MAX_PARTICLES));
    assign pair_skip  = (r_count < CW'(2)) || (r_box_length == 16'd0);
    assign pair_end   = (CW'(r_j) == r_count - CW'(1)) && (CW'(r_i) == r_count - CW'(2));
    assign emit       = (7'(r_ridx) < nb_eff);
    assign rot_step   = (r_state == S_REPORT) && (!emit || !o_out_valid || i_out_ready);
    assign out_load   = rot_step && emit;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_LOAD:   if (in_acc && i_last_particle) n_state = S_THR;
            S_THR: begin
                if (r_tk == BW'(NUM_BINS) && !r_t1v && !r_t2v) begin
                    n_state = pair_skip ? S_DRAIN : S_PAIR;
                end
            end
            S_PAIR:   if (pair_end) n_state = S_DRAIN;
            S_DRAIN:  if (r_drain == DW'(DRAIN_CYC)) n_state = S_REPORT;
            S_REPORT: if (rot_step && r_ridx == BW'(NUM_BINS - 1)) n_state = S_LOAD;
            default:  n_state = S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_LOAD;
            r_count   <= '0;
            r_dropped <= 1'b0;
            r_frames  <= '0;
            r_i       <= '0;
            r_j       <= '0;
            r_tk      <= '0;
            r_t1v     <= 1'b0;
            r_t2v     <= 1'b0;
            r_drain   <= '0;
            r_ridx    <= '0;
        end else begin
            r_state <= n_state;
            r_t2v   <= r_t1v;
            r_t1v   <= 1'b0;
            unique case (r_state)
                S_LOAD: begin
                    r_tk <= '0;
                    if (in_acc) begin
                        if (store_ok) begin
                            r_count <= r_count + CW'(1);
                        end else begin
                            r_dropped <= 1'b1;
                        end
                        if (i_last_particle && r_frames != SAT32) begin
                            r_frames <= r_frames + 32'd1;
                        end
                    end
                end
                S_THR: begin
                    if (r_tk != BW'(NUM_BINS)) begin
                        r_t1v <= 1'b1;
                        r_tk  <= r_tk + BW'(1);
                    end
                    r_i     <= '0;
                    r_j     <= AW'(1);
                    r_drain <= '0;
                end
                S_PAIR: begin
                    if (CW'(r_j) == r_count - CW'(1)) begin
                        r_i <= r_i + AW'(1);
                        r_j <= r_i + AW'(2);
                    end else begin
                        r_j <= r_j + AW'(1);
                    end
                end
                S_DRAIN: begin
                    r_drain <= r_drain + DW'(1);
                    r_ridx  <= '0;
                end
                S_REPORT: begin
                    if (rot_step) begin
                        r_ridx <= r_ridx + BW'(1);
                        if (r_ridx == BW'(NUM_BINS - 1)) begin
                            r_count   <= '0;
                            r_dropped <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Squared bin edges: ((k+1)*bin_size)^2, two registered multiplies.
    always_ff @(posedge i_clk) begin
        r_edge <= EDGE_W'(7'(r_tk) + 7'd1) * EDGE_W'(bs_eff);
        r_thr  <= THR_W'(r_edge) * THR_W'(r_edge);
    end

    // Coordinates are kept at COORD_BITS; z is read back as signed.
    logic [COORD_BITS+15:0] wx, wy, wz;
    assign wx = (COORD_BITS + 16)'(i_pos_x);
    assign wy = (COORD_BITS + 16)'(i_pos_y);
    assign wz = (COORD_BITS + 16)'($unsigned(i_pos_z));

    t_cell_ctl       pipe_ctl;
    logic [D2_W-1:0] pipe_d2;

    pdh_pair_pipe #(
        .MAX_PARTICLES (MAX_PARTICLES),
        .COORD_BITS    (COORD_BITS),
        .AW            (AW),
        .D2_W          (D2_W)
    ) u_pipe (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_wr_en      (in_acc && store_ok),
        .i_wr_addr    (r_count[AW-1:0]),
        .i_wr_x       (wx[COORD_BITS-1:0]),
        .i_wr_y       (wy[COORD_BITS-1:0]),
        .i_wr_z       (wz[COORD_BITS-1:0]),
        .i_issue      (r_state == S_PAIR),
        .i_addr_a     (r_i),
        .i_addr_b     (r_j),
        .i_box_length (r_box_length),
        .i_box_sq     (r_box_sq),
        .o_ctl        (pipe_ctl),
        .o_d2         (pipe_d2)
    );

    // Bin chain. Distances flow from cell 0 upward; edges shift in at the top
    // and move down; during the report the counts rotate toward cell 0.
    t_cell_ctl        c_ctl  [NUM_BINS+1];
    logic [D2_W-1:0]  c_d2   [NUM_BINS+1];
    logic [THR_W-1:0] c_thr  [NUM_BINS+1];
    logic [31:0]      c_hist [NUM_BINS];

    assign c_ctl[0]        = pipe_ctl;
    assign c_d2[0]         = pipe_d2;
    assign c_thr[NUM_BINS] = r_thr;

    for (genvar k = 0; k < NUM_BINS; k++) begin : g_cell
        pdh_bin_cell #(
            .D2_W (D2_W)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (c_ctl[k]),
            .i_d2        (c_d2[k]),
            .i_thr       (c_thr[k+1]),
            .i_thr_shift (r_t2v),
            .i_is_last   (7'(k) == nb_eff - 7'd1),
            .i_rotate    (rot_step),
            .i_hist      (c_hist[(k + 1) % NUM_BINS]),
            .o_ctl       (c_ctl[k+1]),
            .o_d2        (c_d2[k+1]),
            .o_thr       (c_thr[k]),
            .o_hist      (c_hist[k])
        );
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (out_load) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            o_bin_index         <= 6'(r_ridx);
            o_bin_total         <= c_hist[0];
            o_frames_sampled    <= r_frames;
            o_capacity_overflow <= r_dropped;
            o_last_bin          <= (7'(r_ridx) == nb_eff - 7'd1);
        end
    end

    // A finished report must leave a clean frame behind.
    `PDH_ASSERT_NEXT(a_frame_cleared, (r_state == S_REPORT && n_state == S_LOAD), (r_count == '0 && !r_dropped), "frame state not cleared after report")
    // The final bin of a report carries the last index in use.
    `PDH_ASSERT_NOW(a_last_bin_index, (o_out_valid && o_last_bin), (7'(o_bin_index) == nb_eff - 7'd1), "last bin flag on wrong index")
    // The frame counter never moves backward.
    `PDH_ASSERT_NEXT(a_frames_monotonic, 1'b1, (r_frames >= $past(r_frames)), "frame count decreased")
    // No pair is issued once the input side is open again.
    `PDH_ASSERT_NOW(a_no_pair_while_loading, (o_in_ready), (r_state != S_PAIR && !r_t1v && !r_t2v), "pair or edge work while loading")
endmodule

// ===== bench/pair_distance_histogram_pbc_core_tb.sv =====
// Self-checking testbench for pair_distance_histogram_pbc_core.
// Depends on pdh_pkg and the core RTL; predicts each histogram report in-bench.
`timescale 1ns / 1ps

module pair_distance_histogram_pbc_core_tb;
    import pdh_pkg::*;

    localparam int CAPACITY = 256;
    localparam int BIN_COUNT = 64;
    localparam longint CYCLE_LIMIT = 64'd3_000_000;
    // Register index that maps to no register.
    localparam logic [CFG_AW-1:0] CFG_UNMAPPED = 2'd3;

    typedef struct {
        logic [15:0]        x;
        logic [15:0]        y;
        logic signed [15:0] z;
        logic               last;
    } t_particle;

    typedef struct {
        logic [5:0]  index;
        logic [31:0] total;
        logic [31:0] frames;
        logic        dropped;
        logic        last;
    } t_bin_report;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_AW-1:0] i_cfg_addr = CFG_BOX_LENGTH;
    logic [15:0] i_cfg_data = '0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    logic [15:0] i_pos_x = '0;
    logic [15:0] i_pos_y = '0;
    logic signed [15:0] i_pos_z = '0;
    logic i_last_particle = 1'b0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    logic [5:0] o_bin_index;
    logic [31:0] o_bin_total;
    logic [31:0] o_frames_sampled;
    logic o_capacity_overflow;
    logic o_last_bin;

    pair_distance_histogram_pbc_core uut (.*);

    always #5 i_clk = ~i_clk;

    // Predictor state.
    logic [15:0] box_len = 16'd65535;
    logic [15:0] bin_width = 16'd1024;
    logic [6:0]  bins_cfg = 7'd64;
    logic [15:0] xs[CAPACITY];
    logic [15:0] ys[CAPACITY];
    logic signed [15:0] zs[CAPACITY];
    int unsigned loaded = 0;
    logic [31:0] hist[BIN_COUNT];
    logic [31:0] frame_total = '0;
    logic dropped = 1'b0;

    t_particle pending_particles[$];
    t_bin_report expected_bins[$];
    int errors = 0;
    longint cycles = 0;

    initial foreach (hist[k]) hist[k] = '0;

    function automatic longint fold(longint d, longint len);
        longint mag, q;
        mag = d < 0 ? -d : d;
        q = (2 * mag + len) / (2 * len);
        return d < 0 ? d + q * len : d - q * len;
    endfunction

    function automatic longint floor_sqrt(longint v);
        longint r;
        r = longint'($sqrt(real'(v)));
        while (r * r > v) r--;
        while ((r + 1) * (r + 1) <= v) r++;
        return r;
    endfunction

    function automatic int unsigned live_bins();
        if (bins_cfg == 0) return 1;
        if (bins_cfg > BIN_COUNT) return BIN_COUNT;
        return bins_cfg;
    endfunction

    // Applies one accepted particle; a frame end runs the pair pass and queues the report.
    task automatic predict_particle(t_particle p);
        longint len, bs, dx, dy, dz, d2, b;
        int unsigned nb, kb;
        t_bin_report r;
        if (loaded < CAPACITY) begin
            xs[loaded] = p.x;
            ys[loaded] = p.y;
            zs[loaded] = p.z;
            loaded++;
        end else begin
            dropped = 1'b1;
        end
        if (!p.last) return;
        if (frame_total != SAT32) frame_total++;
        nb = live_bins();
        len = box_len;
        bs = bin_width == 0 ? 1 : bin_width;
        if (len != 0) begin
            for (int i = 0; i + 1 < loaded; i++) begin
                for (int j = i + 1; j < loaded; j++) begin
                    dx = fold(longint'(xs[i]) - longint'(xs[j]), len);
                    dy = fold(longint'(ys[i]) - longint'(ys[j]), len);
                    dz = longint'(zs[i]) - longint'(zs[j]);
                    d2 = dx * dx + dy * dy + dz * dz;
                    if (4 * d2 < len * len) begin
                        b = floor_sqrt(d2) / bs;
                        kb = b >= nb ? nb - 1 : int'(b);
                        hist[kb] = hist[kb] > SAT32 - 2 ? SAT32 : hist[kb] + 2;
                    end
                end
            end
        end
        for (int k = 0; k < nb; k++) begin
            r.index = k[5:0];
            r.total = hist[k];
            r.frames = frame_total;
            r.dropped = dropped;
            r.last = (k + 1 == nb);
            expected_bins.push_back(r);
        end
        loaded = 0;
        dropped = 1'b0;
    endtask

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic int gap_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    endfunction

    // Idling mode: 0 means no gaps, so some stretches run at full rate.
    int tx_mode = 1;
    int rx_mode = 1;
    int tx_gap = 0;
    int rx_gap = 0;

    // Driver: one transaction presented at a time, held until accepted.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) predict_particle(pending_particles.pop_front());
            if (!i_in_valid || o_in_ready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    i_in_valid <= 1'b0;
                end else if (pending_particles.size() > 0) begin
                    i_in_valid <= 1'b1;
                    i_pos_x <= pending_particles[0].x;
                    i_pos_y <= pending_particles[0].y;
                    i_pos_z <= pending_particles[0].z;
                    i_last_particle <= pending_particles[0].last;
                    if (tx_mode != 0) tx_gap = gap_len();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compares each accepted bin transaction against the oldest expectation.
    always @(posedge i_clk) begin
        t_bin_report e;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (expected_bins.size() == 0) begin
                    report_mismatch("unexpected bin transaction, index", o_bin_index, -1);
                end else begin
                    e = expected_bins.pop_front();
                    if (o_bin_index !== e.index) report_mismatch("bin_index", o_bin_index, e.index);
                    if (o_bin_total !== e.total) report_mismatch("bin_total", o_bin_total, e.total);
                    if (o_frames_sampled !== e.frames)
                        report_mismatch("frames_sampled", o_frames_sampled, e.frames);
                    if (o_capacity_overflow !== e.dropped)
                        report_mismatch("capacity_overflow", o_capacity_overflow, e.dropped);
                    if (o_last_bin !== e.last) report_mismatch("last_bin", o_last_bin, e.last);
                end
            end
            if (rx_gap > 0) begin
                rx_gap--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
                if (rx_mode != 0 && $urandom_range(0, 3) == 0) rx_gap = gap_len();
            end
        end
    end

    // Watchdog on total run length.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic add_particle(logic [15:0] x, logic [15:0] y, logic [15:0] z, logic last);
        t_particle p;
        p.x = x;
        p.y = y;
        p.z = z;
        p.last = last;
        pending_particles.push_back(p);
    endtask

    // A well-formed frame of n particles with random positions, clustered or spread.
    task automatic add_frame(int n);
        logic [15:0] cx, cy, cz;
        int spread;
        cx = 16'($urandom);
        cy = 16'($urandom);
        cz = 16'($urandom);
        spread = $urandom_range(0, 1) ? 32'hFFFF : int'($urandom_range(16, 4000));
        for (int i = 0; i < n; i++) begin
            if (spread == 32'hFFFF)
                add_particle(16'($urandom), 16'($urandom), 16'($urandom), i == n - 1);
            else
                add_particle(16'(cx + $urandom_range(0, spread)),
                             16'(cy + $urandom_range(0, spread)),
                             16'(cz + $urandom_range(0, spread)), i == n - 1);
        end
    endtask

    // Waits until every queued particle went in and every report came out,
    // then leaves the pipeline time to settle before a register write.
    task automatic wait_idle();
        while (pending_particles.size() > 0 || i_in_valid || expected_bins.size() > 0)
            @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_AW-1:0] addr, logic [15:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (addr)
            CFG_BOX_LENGTH:  box_len = data;
            CFG_BIN_SIZE:    bin_width = data;
            CFG_BINS_IN_USE: bins_cfg = data[6:0];
            default: ;
        endcase
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed frames at reset settings: lone particle, coordinate extremes,
        // and points straddling the periodic boundary.
        add_particle(16'h0000, 16'h0000, 16'h8000, 1'b1);
        add_particle(16'h0000, 16'h0000, 16'h7FFF, 1'b0);
        add_particle(16'hFFFF, 16'hFFFF, 16'h8000, 1'b0);
        add_particle(16'h0010, 16'hFFF0, 16'h0000, 1'b0);
        add_particle(16'hFFF0, 16'h0010, 16'h0000, 1'b0);
        add_particle(16'h5555, 16'hAAAA, 16'h5555, 1'b1);
        wait_idle();

        // Box 1000 gives the round-half case at differences of 500 and 1500.
        write_reg(CFG_BOX_LENGTH, 16'd1000);
        write_reg(CFG_BIN_SIZE, 16'd0);
        write_reg(CFG_BINS_IN_USE, 16'd0);
        add_particle(16'd0, 16'd0, 16'sd0, 1'b0);
        add_particle(16'd500, 16'd0, 16'sd0, 1'b0);
        add_particle(16'd1500, 16'd0, 16'sd0, 1'b0);
        add_particle(16'd1, 16'd1, 16'sd1, 1'b1);
        wait_idle();

        write_reg(CFG_BOX_LENGTH, 16'd0);
        write_reg(CFG_BINS_IN_USE, 16'd127);
        add_particle(16'd3, 16'd3, 16'sd3, 1'b0);
        add_particle(16'd4, 16'd3, 16'sd3, 1'b1);
        wait_idle();

        // Unknown register index is ignored by the block.
        write_reg(CFG_UNMAPPED, 16'hFFFF);
        write_reg(CFG_BOX_LENGTH, 16'd1);
        write_reg(CFG_BIN_SIZE, 16'hFFFF);
        write_reg(CFG_BINS_IN_USE, 16'd1);
        add_particle(16'd7, 16'd9, -16'sd5, 1'b0);
        add_particle(16'd7, 16'd9, -16'sd5, 1'b1);
        wait_idle();

        // Capacity exceeded: one frame of capacity plus a few, on a tiny box
        // so that the long pair pass stays cheap to predict.
        write_reg(CFG_BOX_LENGTH, 16'd3);
        write_reg(CFG_BIN_SIZE, 16'd1);
        write_reg(CFG_BINS_IN_USE, 16'd2);
        for (int i = 0; i < CAPACITY + 3; i++)
            add_particle(16'($urandom), 16'($urandom), 16'($urandom), i == CAPACITY + 2);
        wait_idle();

        // Random phases through several register settings.
        for (int phase = 0; phase < 6; phase++) begin
            tx_mode = phase % 3;
            rx_mode = (phase + 1) % 3;
            write_reg(CFG_BOX_LENGTH, phase == 0 ? 16'hFFFF : 16'($urandom_range(1, 65535)));
            write_reg(CFG_BIN_SIZE, phase == 1 ? 16'd1 : 16'($urandom_range(1, 8000)));
            write_reg(CFG_BINS_IN_USE, phase == 2 ? 16'd64 : 16'($urandom_range(1, 64)));
            for (int f = 0; f < 2; f++) begin
                add_frame($urandom_range(0, 4) == 0 ? 1 : $urandom_range(2, 10));
            end
            wait_idle();
        end

        while (pending_particles.size() > 0 || expected_bins.size() > 0 || i_in_valid)
            @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/pdh_pkg.sv
hw/rtl/pdh_bin_cell.sv
hw/rtl/pdh_pair_pipe.sv
hw/rtl/pair_distance_histogram_pbc_core.sv
bench/pair_distance_histogram_pbc_core_tb.sv
